// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

	// request kinds carried on the slave-side tuser
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_REPORT = 2'd1,
		OP_UPDONE = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	// result gesture codes
	typedef enum logic [2:0] {
		GEST_NONE     = 3'd0,
		GEST_TAP      = 3'd1,
		GEST_COOLDOWN = 3'd2,
		GEST_RIGHT    = 3'd3,
		GEST_LEFT     = 3'd4,
		GEST_DOWN     = 3'd5,
		GEST_UP       = 3'd6,
		GEST_UNCLASS  = 3'd7
	} gesture_t;

	// mode state, one-hot inside the block
	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_REC    = 3'b010,
		MODE_UPLOAD = 3'b100
	} mode_t;

	// mode as reported on the result
	localparam logic [1:0] MODE_CODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_CODE_REC    = 2'd1;
	localparam logic [1:0] MODE_CODE_UPLOAD = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_ADDR_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 16;
	localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_SWIPE  = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TAP_DRIFT  = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TAP_DUR    = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TAP_COOL   = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_LIFT_TMO   = 3'd4;

	// register values after reset
	localparam logic [7:0]  RST_MIN_SWIPE = 8'd30;
	localparam logic [7:0]  RST_TAP_DRIFT = 8'd20;
	localparam logic [15:0] RST_TAP_DUR   = 16'd500;
	localparam logic [15:0] RST_TAP_COOL  = 16'd500;
	localparam logic [15:0] RST_LIFT_TMO  = 16'd50;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		c = MODE_CODE_IDLE;
		unique case (m)
			MODE_IDLE:   c = MODE_CODE_IDLE;
			MODE_REC:    c = MODE_CODE_REC;
			MODE_UPLOAD: c = MODE_CODE_UPLOAD;
			default:     c = MODE_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/touch_tap_swipe_classifier_core.sv =====
// touch tap / swipe classifier
//
// slave side: one request per item; tuser carries the kind (millisecond tick,
// touch report, upload finished), tdata the finger count and the x/y point
// master side: one result per request with gesture, mode after the request
// and the two mode-step pulses
// cfg port: write cfg_wdata to register cfg_addr whenever cfg_wr_en is high,
// only while no request is in flight
//
// path: an accepted request is held in the input register, then is classified
// into the result register, which drives m_tvalid; while that register holds
// a result that is not taken, the request waits in the input register
// throughput: one request per cycle while results are taken; the whole update
// of the contact and mode state is one pass of compares and time subtracts
// between the input register and the result register
// stall: while m_tready is low the result register holds; one more request is
// taken into the input register, then s_tready drops until the result leaves
// reset: clock, contact tracking and mode clear to zero / idle, registers
// return to their defaults, both pipeline registers empty
module touch_tap_swipe_classifier_core
	import tsc_pkg::*;
#(
	parameter int unsigned TIME_BITS  = 32,
	parameter int unsigned COORD_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [23:0]              s_tdata,   // finger_count[7:0], pos_x[15:8], pos_y[23:16]
	input  logic [1:0]               s_tuser,   // opcode[1:0]
	// result channel
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [7:0]               m_tdata,   // gesture[2:0], mode[4:3], start_recording[5],
	                                            // start_upload[6], zero[7]
	// configuration writes
	input  logic                     cfg_wr_en,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	// configuration registers
	logic [7:0]  min_swipe_q;
	logic [7:0]  tap_drift_q;
	logic [15:0] tap_dur_q;
	logic [15:0] tap_cool_q;
	logic [15:0] lift_tmo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_swipe_q <= RST_MIN_SWIPE;
			tap_drift_q <= RST_TAP_DRIFT;
			tap_dur_q   <= RST_TAP_DUR;
			tap_cool_q  <= RST_TAP_COOL;
			lift_tmo_q  <= RST_LIFT_TMO;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_MIN_SWIPE: min_swipe_q <= cfg_wdata[7:0];
				REG_TAP_DRIFT: tap_drift_q <= cfg_wdata[7:0];
				REG_TAP_DUR:   tap_dur_q   <= cfg_wdata;
				REG_TAP_COOL:  tap_cool_q  <= cfg_wdata;
				REG_LIFT_TMO:  lift_tmo_q  <= cfg_wdata;
				default:       ; // writes past the register list are dropped
			endcase
		end
	end

	// input register
	logic      valid_s1;
	opcode_t   op_s1;
	logic      count_nz_s1;
	logic [7:0] px_s1;
	logic [7:0] py_s1;

	logic in_take;
	logic advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1       <= opcode_t'(s_tuser);
			count_nz_s1 <= |s_tdata[7:0];
			px_s1       <= s_tdata[15:8];
			py_s1       <= s_tdata[23:16];
		end
	end

	// contact and mode state
	logic [TIME_BITS-1:0]  now_q;
	logic [TIME_BITS-1:0]  start_ms_q;
	logic [TIME_BITS-1:0]  report_ms_q;
	logic [TIME_BITS-1:0]  tap_ms_q;
	logic                  touching_q;
	logic [COORD_BITS-1:0] first_x_q;
	logic [COORD_BITS-1:0] first_y_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	mode_t                 mode_q;

	// next-state logic
	logic [TIME_BITS-1:0]  now_n;
	logic                  is_report;
	logic                  touch_start;
	logic                  lift_report;
	logic [TIME_BITS-1:0]  since_report;
	logic [TIME_BITS-1:0]  since_start;
	logic [TIME_BITS-1:0]  since_tap;
	logic                  timed_out;
	logic                  ended;
	logic [COORD_BITS-1:0] ax;
	logic [COORD_BITS-1:0] ay;
	logic                  is_tap;
	logic                  tap_ok;
	logic                  is_swipe;
	gesture_t              gest_n;
	mode_t                 mode_n;
	logic                  rec_pulse;
	logic                  up_pulse;

	always_comb begin
		now_n     = (op_s1 == OP_TICK) ? now_q + 1'b1 : now_q;
		is_report = (op_s1 == OP_REPORT) && count_nz_s1;
		touch_start = is_report && !touching_q;
		lift_report = (op_s1 == OP_REPORT) && !count_nz_s1 && touching_q;

		// a fresh report pins the report time to now, so it never times out
		since_report = now_n - report_ms_q;
		timed_out    = touching_q && !is_report && (since_report > TIME_BITS'(lift_tmo_q));
		ended        = lift_report || timed_out;

		// an ending contact never saw a report in this request, so the
		// stored points and start time are the ones to judge
		ax = (last_x_q >= first_x_q) ? last_x_q - first_x_q : first_x_q - last_x_q;
		ay = (last_y_q >= first_y_q) ? last_y_q - first_y_q : first_y_q - last_y_q;
		since_start = now_n - start_ms_q;
		since_tap   = now_n - tap_ms_q;

		is_tap   = (ax <= COORD_BITS'(tap_drift_q)) && (ay <= COORD_BITS'(tap_drift_q))
		           && (since_start < TIME_BITS'(tap_dur_q));
		tap_ok   = since_tap > TIME_BITS'(tap_cool_q);
		is_swipe = (ax > COORD_BITS'(min_swipe_q)) || (ay > COORD_BITS'(min_swipe_q));

		// upload finished only matters while uploading
		mode_n = mode_q;
		if (op_s1 == OP_UPDONE && mode_q == MODE_UPLOAD) begin
			mode_n = MODE_IDLE;
		end

		gest_n    = GEST_NONE;
		rec_pulse = 1'b0;
		up_pulse  = 1'b0;
		if (ended) begin
			if (is_tap) begin
				if (tap_ok) begin
					gest_n = GEST_TAP;
					unique case (mode_n)
						MODE_IDLE: begin
							mode_n    = MODE_REC;
							rec_pulse = 1'b1;
						end
						MODE_REC: begin
							mode_n   = MODE_UPLOAD;
							up_pulse = 1'b1;
						end
						MODE_UPLOAD: mode_n = MODE_UPLOAD; // tap only restarts cooldown
						default:     mode_n = MODE_IDLE;
					endcase
				end else begin
					gest_n = GEST_COOLDOWN;
				end
			end else if (is_swipe) begin
				// larger axis wins, ties go vertical
				if (ax > ay) begin
					gest_n = (last_x_q > first_x_q) ? GEST_RIGHT : GEST_LEFT;
				end else begin
					gest_n = (last_y_q > first_y_q) ? GEST_DOWN : GEST_UP;
				end
			end else begin
				gest_n = GEST_UNCLASS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			start_ms_q  <= '0;
			report_ms_q <= '0;
			tap_ms_q    <= '0;
			touching_q  <= 1'b0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			mode_q      <= MODE_IDLE;
		end else if (advance) begin
			now_q  <= now_n;
			mode_q <= mode_n;
			if (touch_start) begin
				first_x_q  <= COORD_BITS'(px_s1);
				first_y_q  <= COORD_BITS'(py_s1);
				start_ms_q <= now_n;
			end
			if (is_report) begin
				last_x_q    <= COORD_BITS'(px_s1);
				last_y_q    <= COORD_BITS'(py_s1);
				report_ms_q <= now_n;
			end
			if (ended && is_tap && tap_ok) begin
				tap_ms_q <= now_n;
			end
			if (ended) begin
				touching_q <= 1'b0;
			end else if (is_report) begin
				touching_q <= 1'b1;
			end
		end
	end

	// result register
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {1'b0, up_pulse, rec_pulse, mode_code(mode_n), gest_n};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
